/* rtl/bsri_pkg.sv */
// bsri_pkg: shared types, sizes and codes for the bounded sorted region table
// used by bounded_sorted_region_insert and bsri_table; no dependencies
`timescale 1ns / 1ps

package bsri_pkg;

	// table geometry
	localparam int DEPTH   = 1024;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// field widths fixed by the interface
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;
	localparam int ADDR_W  = 64;
	localparam int LEN_W   = 64;
	localparam int RIDX_W  = 10;
	localparam int OUT_W   = 11;
	localparam int LIMIT_W = 11;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	// common widths for mixed compares
	localparam int CAP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int RCMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_REJECT = 2'd1,
		STAT_RANGE  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORDER = 2'd0,
		CFG_LIMIT = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  length;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [IDX_W-1:0] addr;
	} mem_req_t;

endpackage

/* rtl/bsri_table.sv */
// bsri_table: single-port entry store for the region table, registered read
// depends on bsri_pkg for entry_t, mem_req_t and DEPTH
`timescale 1ns / 1ps

module bsri_table
	import bsri_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	input  entry_t   wdata,
	output entry_t   rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// one access per cycle: write or registered read
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem_q[req.addr] <= wdata;
			end else begin
				rdata_q <= mem_q[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bounded_sorted_region_insert.sv */
// bounded_sorted_region_insert: sorted region table with a kept-entry limit
// depends on bsri_pkg and bsri_table (single-port entry store)
`timescale 1ns / 1ps

// Usage
//   Command channel: drive action and payload with start high; the beat is
//   taken at a rising edge with start high and busy low. busy then stays high
//   until an insert or in-range read ends; other items leave it low. Each
//   item has one result, done high for one cycle; the receiver cannot stall it.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 order_mode,
//   1 keep_limit) and cfg_data; cfg_ready is always high, write while idle.
//   Steps, all through the one single-port table memory (a read or a write
//   each cycle, read data registered):
//     clear or unused action: result on the next cycle
//     read: one table read, none if the index is not below the count
//     insert: a read and a compare per binary search probe (up to
//       ceil(log2(count+1)) probes), a decide step, then a read and a write
//       per entry moved down and a final write to place the new entry
//   A new command is accepted in the cycle its predecessor's result shows.
//   Reset: count zero, order_mode 0, keep_limit 1024; the table contents
//   are not cleared, as only entries below the count are ever read.

module bounded_sorted_region_insert
	import bsri_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic [ACT_W-1:0]      action,
	input  logic [ADDR_W-1:0]     region_base,
	input  logic [LEN_W-1:0]      region_length,
	input  logic [RIDX_W-1:0]     read_index,
	// config channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// result
	output logic                  done,
	output logic [STAT_W-1:0]     status,
	output logic [OUT_W-1:0]      position,
	output logic [OUT_W-1:0]      entry_count,
	output logic [ADDR_W-1:0]     out_base,
	output logic [LEN_W-1:0]      out_length
);

	state_t state_q, state_d;

	logic               order_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   lo_q, hi_q, mid_q, pos_q, newcnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  base_q;
	logic [LEN_W-1:0]   len_q;

	logic               done_q;
	logic [STAT_W-1:0]  status_q;
	logic [OUT_W-1:0]   position_q, count_out_q;
	logic [ADDR_W-1:0]  out_base_q;
	logic [LEN_W-1:0]   out_len_q;

	mem_req_t mem_req;
	entry_t   mem_wdata, mem_rdata;

	logic               accept;
	logic [CNT_W-1:0]   mid;
	logic [CAP_W-1:0]   cap_w;
	logic [CNT_W-1:0]   cap;
	logic [CNT_W:0]     cnt_inc;
	logic [CNT_W-1:0]   newcnt, newcnt_m1;
	logic               srch_more, fits, need_shift, shift_more, goes_after;
	logic               ridx_ok;
	logic [CNT_W-1:0]   idx_m1;

	// result strobe signals from the sequencer
	logic               rsp_fire, rsp_rd;
	logic [STAT_W-1:0]  rsp_status;
	logic [CNT_W-1:0]   rsp_pos, rsp_cnt;

	bsri_table u_table (
		.clk   (clk),
		.req   (mem_req),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// effective limit and the count after an accepted insert
	assign cap_w = (CAP_W'(limit_q) > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : CAP_W'(limit_q);
	assign cap   = CNT_W'(cap_w);
	assign cnt_inc   = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};
	assign newcnt    = (cnt_inc > {1'b0, cap}) ? cap : CNT_W'(cnt_inc);
	assign newcnt_m1 = newcnt - CNT_W'(1);

	// search step and shift bookkeeping
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign srch_more  = lo_q < hi_q;
	assign fits       = lo_q < cap;
	assign need_shift = newcnt_m1 > lo_q;
	assign idx_m1     = CNT_W'(idx_q) - CNT_W'(1);
	assign shift_more = idx_m1 > pos_q;
	assign ridx_ok    = RCMP_W'(read_index) < RCMP_W'(count_q);

	// the shared key compare: stored entry sorts strictly after the new one
	assign goes_after = order_q ? (mem_rdata.length < len_q) : (mem_rdata.base > base_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory request and result strobe
	always_comb begin
		state_d       = state_q;
		mem_req       = '0;
		mem_wdata     = mem_rdata;
		rsp_fire      = 1'b0;
		rsp_rd        = 1'b0;
		rsp_status    = STAT_DONE;
		rsp_pos       = '0;
		rsp_cnt       = count_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_INSERT: begin
							state_d = ST_SRCH;
						end
						ACT_READ: begin
							if (ridx_ok) begin
								mem_req.en   = 1'b1;
								mem_req.addr = IDX_W'(read_index);
								state_d      = ST_READ;
							end else begin
								rsp_fire   = 1'b1;
								rsp_status = STAT_RANGE;
							end
						end
						ACT_CLEAR: begin
							rsp_fire = 1'b1;
							rsp_cnt  = '0;
						end
						default: begin
							rsp_fire = 1'b1;
						end
					endcase
				end
			end
			ST_SRCH: begin
				if (srch_more) begin
					mem_req.en   = 1'b1;
					mem_req.addr = IDX_W'(mid);
					state_d      = ST_CMP;
				end else if (fits) begin
					state_d = need_shift ? ST_SHIFT_RD : ST_PUT;
				end else begin
					rsp_fire   = 1'b1;
					rsp_status = STAT_REJECT;
					rsp_pos    = lo_q;
					state_d    = ST_IDLE;
				end
			end
			ST_CMP: begin
				state_d = ST_SRCH;
			end
			ST_SHIFT_RD: begin
				mem_req.en   = 1'b1;
				mem_req.addr = IDX_W'(idx_m1);
				state_d      = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				mem_req.en   = 1'b1;
				mem_req.we   = 1'b1;
				mem_req.addr = idx_q;
				state_d      = shift_more ? ST_SHIFT_RD : ST_PUT;
			end
			ST_PUT: begin
				mem_req.en   = 1'b1;
				mem_req.we   = 1'b1;
				mem_req.addr = IDX_W'(pos_q);
				mem_wdata    = '{base: base_q, length: len_q};
				rsp_fire     = 1'b1;
				rsp_pos      = pos_q;
				rsp_cnt      = newcnt_q;
				state_d      = ST_IDLE;
			end
			ST_READ: begin
				rsp_fire = 1'b1;
				rsp_rd   = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORDER: order_q <= cfg_data[0];
				CFG_LIMIT: limit_q <= LIMIT_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (rsp_fire) begin
			count_q <= rsp_cnt;
		end
	end

	// search and shift datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lo_q   <= '0;
					hi_q   <= count_q;
					base_q <= region_base;
					len_q  <= region_length;
				end
			end
			ST_SRCH: begin
				mid_q    <= mid;
				pos_q    <= lo_q;
				newcnt_q <= newcnt;
				idx_q    <= IDX_W'(newcnt_m1);
			end
			ST_CMP: begin
				if (goes_after) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + CNT_W'(1);
				end
			end
			ST_SHIFT_WR: begin
				idx_q <= IDX_W'(idx_m1);
			end
			default: ;
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp_fire;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rsp_fire) begin
			status_q    <= rsp_status;
			position_q  <= OUT_W'(rsp_pos);
			count_out_q <= OUT_W'(rsp_cnt);
			out_base_q  <= rsp_rd ? mem_rdata.base : '0;
			out_len_q   <= rsp_rd ? mem_rdata.length : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = count_out_q;
	assign out_base    = out_base_q;
	assign out_length  = out_len_q;

	// a result only shows once the sequencer is back in idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted command either starts work or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted command went nowhere");

	// shift writes stay above the insert position
	a_shift_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT_WR) |-> (CNT_W'(idx_q) > pos_q))
		else $error("shift write at or below insert position");

	// the count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

endmodule
